/* hdl/rrtla_pkg.sv */
`timescale 1ns / 1ps

package rrtla_pkg;

    // Fixed field widths of the command and result ports
    localparam int OPCODE_W     = 2;
    localparam int LOCK_ID_W    = 3;
    localparam int THREAD_ID_W  = 3;
    localparam int HOLDER_NOW_W = 4;

    // Default sizing
    localparam int DEF_LOCKS   = 8;
    localparam int DEF_THREADS = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_REQUEST = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_PASS    = 2'd3
    } t_opcode;

    // Status handed from the operation unit to the top level
    typedef struct packed {
        logic wr_en;
        logic granted;
    } t_op_flags;

endpackage

/* hdl/rrtla_lock_store.sv */
`timescale 1ns / 1ps

module rrtla_lock_store
    import rrtla_pkg::*;
#(
    parameter int LOCKS   = DEF_LOCKS,
    parameter int THREADS = DEF_THREADS,
    localparam int LW     = (LOCKS > 1) ? $clog2(LOCKS) : 1,
    localparam int HW     = $clog2(THREADS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [LW-1:0]      i_rd_addr,
    output logic [THREADS-1:0] o_rd_req,
    output logic [HW-1:0]      o_rd_holder,
    input  logic               i_wr_en,
    input  logic [LW-1:0]      i_wr_addr,
    input  logic [THREADS-1:0] i_wr_req,
    input  logic [HW-1:0]      i_wr_holder
);

    logic [THREADS-1:0] r_req_mem  [0:LOCKS-1];
    logic [HW-1:0]      r_hold_mem [0:LOCKS-1];
    logic [LOCKS-1:0]   r_valid;
    logic [THREADS-1:0] r_rd_req;
    logic [HW-1:0]      r_rd_holder;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_req_mem[i_wr_addr]  <= i_wr_req;
            r_hold_mem[i_wr_addr] <= i_wr_holder;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_req    <= r_req_mem[i_rd_addr];
            r_rd_holder <= r_hold_mem[i_rd_addr];
            r_rd_vld    <= r_valid[i_rd_addr];
        end
    end

    // Entry valid bits: an entry never written reads as its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_req    = r_rd_vld ? r_rd_req : '0;
    assign o_rd_holder = r_rd_vld ? r_rd_holder : HW'(THREADS);

endmodule

/* hdl/rrtla_op_unit.sv */
`timescale 1ns / 1ps

module rrtla_op_unit
    import rrtla_pkg::*;
#(
    parameter int LOCKS   = DEF_LOCKS,
    parameter int THREADS = DEF_THREADS,
    localparam int HW     = $clog2(THREADS + 1)
) (
    input  t_opcode                  i_opcode,
    input  logic [LOCK_ID_W-1:0]     i_lock_id,
    input  logic [THREAD_ID_W-1:0]   i_thread_id,
    input  logic [THREADS-1:0]       i_req,
    input  logic [HW-1:0]            i_holder,
    output logic [THREADS-1:0]       o_req,
    output logic [HW-1:0]            o_holder,
    output t_op_flags                o_flags,
    output logic [HOLDER_NOW_W-1:0]  o_holder_now
);

    localparam logic [HW-1:0] NONE = HW'(THREADS);

    logic                         lock_ok;
    logic                         thread_ok;
    logic [HW-1:0]                t_id;
    logic [THREADS-1:0]           t_bit;
    logic [THREADS-1:0]           req_new;
    logic [THREADS-1:0]           above;
    logic [HW-1:0]                claimed;
    logic [HW-1:0]                first_above;
    logic [HW-1:0]                first_any;
    logic                         any_above;
    logic [HW-1:0]                next_holder;
    logic [HW-1:0]                h_new;
    logic [HW+HOLDER_NOW_W-1:0]   h_wide;

    assign lock_ok   = int'(i_lock_id) < LOCKS;
    assign thread_ok = int'(i_thread_id) < THREADS;
    assign t_id      = HW'(i_thread_id);
    assign t_bit     = {{(THREADS-1){1'b0}}, 1'b1} << i_thread_id;
    assign claimed   = (i_holder == NONE) ? t_id : i_holder;

    always_comb begin
        case (i_opcode)
            OP_REQUEST: req_new = i_req | t_bit;
            OP_RELEASE: req_new = i_req & ~t_bit;
            default:    req_new = i_req;
        endcase
    end

    // Round-robin pick: first requester above the thread, else lowest overall
    always_comb begin
        first_above = NONE;
        first_any   = NONE;
        for (int i = THREADS - 1; i >= 0; i--) begin
            above[i] = req_new[i] && (i > int'(i_thread_id));
            if (above[i]) begin
                first_above = HW'(i);
            end
            if (req_new[i]) begin
                first_any = HW'(i);
            end
        end
    end

    assign any_above   = |above;
    assign next_holder = any_above ? first_above : first_any;

    always_comb begin
        unique case (i_opcode)
            OP_REQUEST, OP_QUERY: h_new = claimed;
            OP_RELEASE, OP_PASS:  h_new = (claimed == t_id) ? next_holder : claimed;
            default:              h_new = claimed;
        endcase
    end

    always_comb begin
        o_req         = req_new;
        o_holder      = h_new;
        o_flags.wr_en = 1'b0;
        o_flags.granted = 1'b0;
        h_wide        = '0;
        if (!lock_ok) begin
            h_wide = (HW + HOLDER_NOW_W)'(THREADS);
        end else if (!thread_ok) begin
            h_wide = {{HOLDER_NOW_W{1'b0}}, i_holder};
        end else begin
            o_flags.wr_en   = 1'b1;
            o_flags.granted = (h_new == t_id);
            h_wide          = {{HOLDER_NOW_W{1'b0}}, h_new};
        end
        o_holder_now = h_wide[HOLDER_NOW_W-1:0];
    end

endmodule

/* hdl/round_robin_token_lock_arbiter_core.sv */
`timescale 1ns / 1ps

// Round-robin token lock arbiter. Each lock keeps a bitmap of requesting threads and
// a holder. An item is a command (request, release, query, pass) on one lock for one
// thread; every item returns exactly one result: whether that thread now holds the
// lock, and who holds it (the value THREADS means free). The block takes an item in
// every cycle: busy is always low. A result appears on o_granted / o_holder_now with
// o_valid high for exactly one cycle and cannot be held off, so capture it on that
// cycle. Items pass the stage and result registers; per item the lock store does one
// read-modify-write: the entry is read at the accepting edge, updated in the
// following cycle and written back, with the write of the item before forwarded to
// it. Locks come out of reset free with no requests; no clearing pass is needed.
module round_robin_token_lock_arbiter_core
    import rrtla_pkg::*;
#(
    parameter int LOCKS   = DEF_LOCKS,
    parameter int THREADS = DEF_THREADS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OPCODE_W-1:0]      i_opcode,
    input  logic [LOCK_ID_W-1:0]     i_lock_id,
    input  logic [THREAD_ID_W-1:0]   i_thread_id,
    output logic                     o_valid,
    output logic                     o_granted,
    output logic [HOLDER_NOW_W-1:0]  o_holder_now
);

    localparam int LW = (LOCKS > 1) ? $clog2(LOCKS) : 1;
    localparam int HW = $clog2(THREADS + 1);

    logic                        accept;
    logic [LW+LOCK_ID_W-1:0]     in_addr_wide;
    logic [LW+LOCK_ID_W-1:0]     stg_addr_wide;
    logic [LW-1:0]               in_addr;
    logic [LW-1:0]               stg_addr;

    // Stage register: the item being worked on
    logic                        r_stg_vld;
    t_opcode                     r_opcode;
    logic [LOCK_ID_W-1:0]        r_lock;
    logic [THREAD_ID_W-1:0]      r_thread;

    // Last write to the store, forwarded to the next item
    logic                        r_fwd_vld;
    logic [LW-1:0]               r_fwd_addr;
    logic [THREADS-1:0]          r_fwd_req;
    logic [HW-1:0]               r_fwd_holder;

    // Result register
    logic                        r_out_vld;
    logic                        r_granted;
    logic [HOLDER_NOW_W-1:0]     r_holder_now;

    logic [THREADS-1:0]          rd_req;
    logic [HW-1:0]               rd_holder;
    logic                        use_fwd;
    logic [THREADS-1:0]          cur_req;
    logic [HW-1:0]               cur_holder;
    logic [THREADS-1:0]          new_req;
    logic [HW-1:0]               new_holder;
    t_op_flags                   flags;
    logic [HOLDER_NOW_W-1:0]     holder_now;
    logic                        wr_en;

    // Never stalls: an item can be taken every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_addr_wide  = {{LW{1'b0}}, i_lock_id};
    assign in_addr       = in_addr_wide[LW-1:0];
    assign stg_addr_wide = {{LW{1'b0}}, r_lock};
    assign stg_addr      = stg_addr_wide[LW-1:0];

    rrtla_lock_store #(
        .LOCKS   (LOCKS),
        .THREADS (THREADS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr   (in_addr),
        .o_rd_req    (rd_req),
        .o_rd_holder (rd_holder),
        .i_wr_en     (wr_en),
        .i_wr_addr   (stg_addr),
        .i_wr_req    (new_req),
        .i_wr_holder (new_holder)
    );

    // The store read at the accepting edge misses the write done on that same edge
    assign use_fwd    = r_fwd_vld && (r_fwd_addr == stg_addr);
    assign cur_req    = use_fwd ? r_fwd_req : rd_req;
    assign cur_holder = use_fwd ? r_fwd_holder : rd_holder;

    rrtla_op_unit #(
        .LOCKS   (LOCKS),
        .THREADS (THREADS)
    ) u_op (
        .i_opcode     (r_opcode),
        .i_lock_id    (r_lock),
        .i_thread_id  (r_thread),
        .i_req        (cur_req),
        .i_holder     (cur_holder),
        .o_req        (new_req),
        .o_holder     (new_holder),
        .o_flags      (flags),
        .o_holder_now (holder_now)
    );

    assign wr_en = r_stg_vld && flags.wr_en;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_stg_vld <= accept;
            r_fwd_vld <= wr_en;
            r_out_vld <= r_stg_vld;
        end
    end

    // Payload: capture the item, hold the forwarded entry, register the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode <= t_opcode'(i_opcode);
            r_lock   <= i_lock_id;
            r_thread <= i_thread_id;
        end
        if (wr_en) begin
            r_fwd_addr   <= stg_addr;
            r_fwd_req    <= new_req;
            r_fwd_holder <= new_holder;
        end
        if (r_stg_vld) begin
            r_granted    <= flags.granted;
            r_holder_now <= holder_now;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_granted    = r_granted;
    assign o_holder_now = r_holder_now;

    // Every accepted item gives exactly one result
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_vld |=> o_valid)
        else $error("item in the stage produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_stg_vld |=> !o_valid)
        else $error("result strobe without an item");

    // A granted thread must be the reported holder
    a_grant_holder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_vld && flags.granted |=>
            o_holder_now == {{(HOLDER_NOW_W-THREAD_ID_W){1'b0}}, $past(r_thread)})
        else $error("granted, but holder differs from thread");

    // A free lock is taken by a request or query from a valid thread
    a_free_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_vld && flags.wr_en && (cur_holder == HW'(THREADS))
            && (r_opcode == OP_REQUEST || r_opcode == OP_QUERY) |=> o_granted)
        else $error("free lock not granted");

endmodule
